// ===== rtl/pdst_pkg.sv =====
// pdst_pkg: shared types and constants of the porous drag source block
// used by the square root pipeline and the top level
`timescale 1ns / 1ps

package pdst_pkg;

  localparam int NumRegs   = 7;
  localparam int AddrW     = 5;
  localparam int SqrtSteps = 32;
  localparam int SqrtStg   = SqrtSteps / 2;

  typedef enum logic [2:0] {
    REG_DENSITY = 3'd0,
    REG_ALPHA_X = 3'd1,
    REG_ALPHA_Y = 3'd2,
    REG_ALPHA_Z = 3'd3,
    REG_BETA_X  = 3'd4,
    REG_BETA_Y  = 3'd5,
    REG_BETA_Z  = 3'd6
  } reg_idx_t;

  localparam logic [31:0] DensityReset = 32'h0001_0000;

  // per-cell data that rides along the speed computation
  typedef struct packed {
    logic [15:0]      idx;
    logic [30:0]      vol;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } side_t;

  // one element of the square root pipeline
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } sq_t;

endpackage

// ===== rtl/pdst_if.sv =====
// pdst_if: valid/ready channel interfaces for cells in and results out
// depends on nothing but the language
`timescale 1ns / 1ps

interface pdst_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_index;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [30:0] cell_volume;
  modport source (output valid, cell_index, vel_x, vel_y, vel_z, cell_volume, input ready);
  modport sink (input valid, cell_index, vel_x, vel_y, vel_z, cell_volume, output ready);
endinterface

interface pdst_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_out;
  logic [31:0] diag_add;
  logic [31:0] src_x_add;
  logic [31:0] src_y_add;
  logic [31:0] src_z_add;
  logic        clipped;
  modport source (output valid, cell_out, diag_add, src_x_add, src_y_add, src_z_add,
                  clipped, input ready);
  modport sink (input valid, cell_out, diag_add, src_x_add, src_y_add, src_z_add,
                clipped, output ready);
endinterface

// ===== rtl/pdst_sqrt.sv =====
// pdst_sqrt: pipelined floor square root of a 64-bit value, two result bits per stage
// depends on pdst_pkg for sq_t and side_t
`timescale 1ns / 1ps

module pdst_sqrt
  import pdst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] x,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [31:0] root,
  output side_t       out_side
);

  function automatic sq_t sq_step(input sq_t s);
    logic [35:0] rr;
    logic [35:0] t;
    sq_t         o;
    rr = {s.rem, s.x[63:62]};
    t  = {2'b00, s.root, 2'b01};
    o.x = {s.x[61:0], 2'b00};
    if (rr >= t) begin
      o.rem  = 34'(rr - t);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rr[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  sq_t   st_r   [SqrtStg];
  side_t side_r [SqrtStg];
  logic  vld_r  [SqrtStg];

  for (genvar i = 0; i < SqrtStg; i++) begin : g_stg
    sq_t   src;
    logic  src_vld;
    side_t src_side;
    if (i == 0) begin : g_first
      assign src      = '{rem: '0, root: '0, x: x};
      assign src_vld  = in_vld;
      assign src_side = in_side;
    end else begin : g_next
      assign src      = st_r[i-1];
      assign src_vld  = vld_r[i-1];
      assign src_side = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i]   <= sq_step(sq_step(src));
        side_r[i] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[SqrtStg-1];
  assign root     = st_r[SqrtStg-1].root;
  assign out_side = side_r[SqrtStg-1];

endmodule

// ===== rtl/porous_drag_source_terms.sv =====
// porous_drag_source_terms: darcy/forchheimer drag terms per mesh cell, top level
// depends on pdst_pkg, pdst_in_if / pdst_out_if and pdst_sqrt
//
// usage:
//  - in_if carries one mesh cell per request: cell number, velocity vector
//    and volume (velocity Q16.16, volume unsigned Q15.16); out_if returns one
//    result per cell in order: diagonal add, three source adds, saturation flag
//  - the seven coefficient registers sit on an apb-style port at byte
//    address 4*i; write them while no cell is in flight
//  - one cell is taken per cycle while the receiver does not stall; a result
//    passes the magnitude and squaring stages, the square root pipeline
//    (two root bits per stage) and 9 coefficient and product stages, the
//    wider multiplies split into partial products at bit 32
//  - every stage advances together when the output register is empty or
//    being taken; while the receiver stalls the whole pipe holds and
//    in_if.ready is low, nothing is lost or repeated
//  - synchronous reset empties the pipe and loads density 1.0 and zero
//    coefficients
`timescale 1ns / 1ps

module porous_drag_source_terms
  import pdst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  pdst_in_if.sink          in_if,
  pdst_out_if.source       out_if,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // configuration registers
  logic [31:0] cfg_r [NumRegs];
  logic [2:0]  cfg_idx;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) cfg_r[i] <= (i == 0) ? DensityReset : 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_idx < 3'(NumRegs))) begin
      cfg_r[cfg_idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DENSITY: cfg_prdata = cfg_r[REG_DENSITY];
      REG_ALPHA_X: cfg_prdata = cfg_r[REG_ALPHA_X];
      REG_ALPHA_Y: cfg_prdata = cfg_r[REG_ALPHA_Y];
      REG_ALPHA_Z: cfg_prdata = cfg_r[REG_ALPHA_Z];
      REG_BETA_X:  cfg_prdata = cfg_r[REG_BETA_X];
      REG_BETA_Y:  cfg_prdata = cfg_r[REG_BETA_Y];
      REG_BETA_Z:  cfg_prdata = cfg_r[REG_BETA_Z];
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // pipeline advance
  logic adv;
  logic out_vld_r;
  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;

  // stage 1: magnitudes
  logic [31:0] vel [3];
  assign vel[0] = in_if.vel_x;
  assign vel[1] = in_if.vel_y;
  assign vel[2] = in_if.vel_z;

  logic  v1_r, v2_r, v3_r;
  side_t s1_r, s2_r, s3_r;
  logic [63:0] sq_r [3];
  logic [63:0] sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.idx <= in_if.cell_index;
      s1_r.vol <= in_if.cell_volume;
      for (int i = 0; i < 3; i++) begin
        s1_r.neg[i] <= vel[i][31];
        s1_r.mag[i] <= vel[i][31] ? 32'(~vel[i] + 32'd1) : vel[i];
      end
      // stage 2: squares
      s2_r <= s1_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= 64'(s1_r.mag[i]) * 64'(s1_r.mag[i]);
      // stage 3: sum of squares, exact in 64 bits
      s3_r  <= s2_r;
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // square root pipeline
  logic        vs;
  logic [31:0] spd;
  side_t       ss;

  pdst_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v3_r),
    .x        (sum_r),
    .in_side  (s3_r),
    .out_vld  (vs),
    .root     (spd),
    .out_side (ss)
  );

  // coefficient and product stages
  logic  va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;
  side_t sa_r, sb_r, sc_r, sd_r, se_r, sf_r, sg_r, sh_r;
  logic [63:0] pb_r  [3];
  logic [48:0] k_r   [3];
  logic [63:0] pcl_r [3];
  logic [48:0] pch_r [3];
  logic [63:0] cd_r  [3];
  logic [63:0] m_r   [3];
  logic [47:0] tr_r;
  logic [62:0] pvl_r [3];
  logic [62:0] pvh_r [3];
  logic [62:0] pdl_r;
  logic [46:0] pdh_r;
  logic [47:0] w_r   [3];
  logic [30:0] dg_g_r, dg_h_r;
  logic        dc_g_r, dc_h_r;
  logic [63:0] prl_r [3];
  logic [47:0] prh_r [3];

  logic [64:0] cd_sum [3];
  logic [64:0] m_sum  [3];
  logic [65:0] tr_sum;
  logic [79:0] w_sum  [3];
  logic [63:0] d_sum;
  logic [64:0] r_sum  [3];
  logic [31:0] src    [3];
  logic [2:0]  sclip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd_sum[i] = {pch_r[i], 16'd0} + 65'(pcl_r[i][63:16]);
      m_sum[i]  = 65'(cd_r[(i+1)%3]) + 65'(cd_r[(i+2)%3]);
      w_sum[i]  = {1'b0, pvh_r[i], 16'd0} + 80'(pvl_r[i][62:16]);
      r_sum[i]  = {1'b0, prh_r[i], 16'd0} + 65'(prl_r[i][63:16]);
      // negative side may reach 2^31, positive side stops one short
      if (sh_r.neg[i]) begin
        sclip[i] = r_sum[i] > 65'h0_8000_0000;
        src[i]   = sclip[i] ? 32'h8000_0000 : 32'(~r_sum[i][31:0] + 32'd1);
      end else begin
        sclip[i] = r_sum[i] > 65'h0_7FFF_FFFF;
        src[i]   = sclip[i] ? 32'h7FFF_FFFF : r_sum[i][31:0];
      end
    end
    tr_sum = 66'(cd_r[0]) + 66'(cd_r[1]) + 66'(cd_r[2]);
    d_sum  = {1'b0, pdh_r, 16'd0} + 64'(pdl_r[62:16]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r <= ss;
      sb_r <= sa_r;
      sc_r <= sb_r;
      sd_r <= sc_r;
      se_r <= sd_r;
      sf_r <= se_r;
      sg_r <= sf_r;
      sh_r <= sg_r;
      for (int i = 0; i < 3; i++) begin
        pb_r[i]  <= 64'(cfg_r[REG_BETA_X + i]) * 64'(spd);
        k_r[i]   <= 49'(cfg_r[REG_ALPHA_X + i]) + 49'(pb_r[i][63:16]);
        pcl_r[i] <= 64'(cfg_r[REG_DENSITY]) * 64'(k_r[i][31:0]);
        pch_r[i] <= 49'(cfg_r[REG_DENSITY]) * 49'(k_r[i][48:32]);
        cd_r[i]  <= cd_sum[i][64] ? '1 : cd_sum[i][63:0];
        m_r[i]   <= m_sum[i][64] ? '1 : m_sum[i][63:0];
        pvl_r[i] <= 63'(se_r.vol) * 63'(m_r[i][31:0]);
        pvh_r[i] <= 63'(se_r.vol) * 63'(m_r[i][63:32]);
        // beyond 48 bits any nonzero magnitude clamps the source
        w_r[i]   <= (|w_sum[i][79:48]) ? '1 : w_sum[i][47:0];
        prl_r[i] <= 64'(sg_r.mag[i]) * 64'(w_r[i][31:0]);
        prh_r[i] <= 48'(sg_r.mag[i]) * 48'(w_r[i][47:32]);
      end
      // beyond 48 bits any nonzero volume clamps the diagonal
      tr_r   <= (|tr_sum[65:48]) ? '1 : tr_sum[47:0];
      pdl_r  <= 63'(se_r.vol) * 63'(tr_r[31:0]);
      pdh_r  <= 47'(se_r.vol) * 47'(tr_r[47:32]);
      dc_g_r <= |d_sum[63:31];
      dg_g_r <= (|d_sum[63:31]) ? 31'h7FFF_FFFF : d_sum[30:0];
      dc_h_r <= dc_g_r;
      dg_h_r <= dg_g_r;
      out_if.cell_out  <= sh_r.idx;
      out_if.diag_add  <= {1'b0, dg_h_r};
      out_if.src_x_add <= src[0];
      out_if.src_y_add <= src[1];
      out_if.src_z_add <= src[2];
      out_if.clipped   <= dc_h_r | (|sclip);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r, out_vld_r} <= '0;
    end else if (adv) begin
      v1_r      <= in_if.valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      va_r      <= vs;
      vb_r      <= va_r;
      vc_r      <= vb_r;
      vd_r      <= vc_r;
      ve_r      <= vd_r;
      vf_r      <= ve_r;
      vg_r      <= vf_r;
      vh_r      <= vg_r;
      out_vld_r <= vh_r;
    end
  end

  assign out_if.valid = out_vld_r;

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

  a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !out_if.diag_add[31])
    else $error("negative diagonal add");

  a_clip_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.clipped) |->
      (out_if.diag_add == 32'h7FFF_FFFF ||
       out_if.src_x_add == 32'h7FFF_FFFF || out_if.src_x_add == 32'h8000_0000 ||
       out_if.src_y_add == 32'h7FFF_FFFF || out_if.src_y_add == 32'h8000_0000 ||
       out_if.src_z_add == 32'h7FFF_FFFF || out_if.src_z_add == 32'h8000_0000))
    else $error("clip flag without a saturated field");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("request taken while output stalls");

endmodule
